FILE: design/fcet_pkg.sv
// Shared types, constants and codes for the FAT chain extent table.
// Used by the run RAM, the compare unit, the sequencer and the top level.
// No dependencies.
`timescale 1ns / 1ps

package fcet_pkg;

  // Table sizes
  localparam int RUN_ENTRIES  = 16;
  localparam int HEAD_ENTRIES = 8;

  // Field widths
  localparam int CL_W   = 28;
  localparam int RIDX_W = $clog2(RUN_ENTRIES);
  localparam int HIDX_W = (HEAD_ENTRIES > 1) ? $clog2(HEAD_ENTRIES) : 1;

  // Cluster constants
  localparam logic [CL_W-1:0] CL_MASK = 28'hfffffff;
  localparam logic [CL_W-1:0] END16   = 28'h000ffff;
  localparam logic [CL_W-1:0] END32A  = 28'hffffff8;
  localparam logic [CL_W-1:0] END32B  = 28'hfffffff;

  // Index limits
  localparam logic [RIDX_W-1:0] RUN_LAST = RIDX_W'(RUN_ENTRIES - 1);
  localparam logic [HIDX_W-1:0] HC_MAX   = HIDX_W'(HEAD_ENTRIES - 1);

  // Commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_ENTRY = 2'd1;
  localparam logic [1:0] CMD_NEXT  = 2'd2;
  localparam logic [1:0] CMD_PREV  = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EOF      = 3'd3;
  localparam logic [2:0] ST_RELOAD   = 3'd4;
  localparam logic [2:0] ST_START    = 3'd5;
  localparam logic [2:0] ST_NOTFOUND = 3'd6;

  // Run RAM write / clear request
  typedef struct packed {
    logic              we;
    logic              clr;
    logic [RIDX_W-1:0] addr;
    logic [CL_W-1:0]   base;
    logic [CL_W-1:0]   len;
  } run_wr_t;

  // Run RAM read data; an entry that is not valid reads as zero
  typedef struct packed {
    logic            valid;
    logic [CL_W-1:0] base;
    logic [CL_W-1:0] len;
  } run_rd_t;

  // Compare unit results for one run against one cluster
  typedef struct packed {
    logic            hit;
    logic            at_last;
    logic            at_base;
    logic            contig;
    logic [CL_W-1:0] last;
    logic [CL_W-1:0] c_inc;
    logic [CL_W-1:0] c_dec;
  } run_cmp_t;

endpackage

FILE: design/fat_chain_extent_table_unit.sv
// FAT chain extent table: each accepted transaction (start, chain entry or query) gives one result.
// One transaction at a time; a query reads one run per cycle through the
// single run RAM read port, so its time grows with the matching run's index.
// Reset (rst, synchronous) empties the table, clears flags, head count and
// fat32_mode; the head stack contents are left as they are.
`timescale 1ns / 1ps

module fat_chain_extent_table_unit import fcet_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [27:0] cluster, [31:28] zero
  input  logic [1:0]  s_tuser,  // [1:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // [27:0] cluster_out, [31:28] zero
  output logic [2:0]  m_tuser   // [2:0] status
);

  localparam logic [2:0] ADDR_MODE = 3'd0;

  logic              fat32_mode;
  logic              res_valid;
  logic              res_ready;
  logic [2:0]        res_status;
  logic [CL_W-1:0]   res_cluster;
  run_wr_t           wr;
  run_rd_t           rd;
  logic [RIDX_W-1:0] raddr;
  logic [CL_W-1:0]   cmp_c;
  run_cmp_t          cmp;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MODE) ? {31'b0, fat32_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fat32_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_MODE) begin
      fat32_mode <= pwdata[0];
    end
  end

  // Output register: load when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {4'b0, res_cluster};
      m_tuser <= res_status;
    end
  end

  fcet_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .fat32_mode  (fat32_mode),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_cmd      (s_tuser),
    .in_cluster  (s_tdata[CL_W-1:0]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_status  (res_status),
    .res_cluster (res_cluster),
    .wr          (wr),
    .raddr       (raddr),
    .rd          (rd),
    .cmp_c       (cmp_c),
    .cmp         (cmp)
  );

  fcet_run_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .raddr (raddr),
    .rd    (rd)
  );

  fcet_run_cmp u_cmp (
    .base (rd.base),
    .len  (rd.len),
    .c    (cmp_c),
    .res  (cmp)
  );

endmodule

FILE: design/fcet_run_ram.sv
// Run table storage: base and length per run, one write and one read port.
// Per-entry valid bits give the cleared state at once on start or reset.
// Depends on fcet_pkg.
`timescale 1ns / 1ps

module fcet_run_ram import fcet_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  run_wr_t           wr,
  input  logic [RIDX_W-1:0] raddr,
  output run_rd_t           rd
);

  logic [2*CL_W-1:0]      mem [RUN_ENTRIES];
  logic [RUN_ENTRIES-1:0] valid;
  logic [RUN_ENTRIES-1:0] valid_next;
  logic [2*CL_W-1:0]      rdata;
  logic                   rvalid;

  // Clear valid bits on start, then mark the written entry
  always_comb begin
    valid_next = wr.clr ? '0 : valid;
    if (wr.we) begin
      valid_next[wr.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  // Write and registered read of the entry data
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= {wr.base, wr.len};
    end
    rdata  <= mem[raddr];
    rvalid <= valid[raddr];
  end

  // Mask entries that were not written since the last clear
  always_comb begin
    rd.valid = rvalid;
    rd.base  = rvalid ? rdata[2*CL_W-1:CL_W] : '0;
    rd.len   = rvalid ? rdata[CL_W-1:0] : '0;
  end

endmodule

FILE: design/fcet_run_cmp.sv
// Shared compare and add unit: tests one run against one cluster.
// Serves chain entry evaluation and every step of the query scan.
// Depends on fcet_pkg.
`timescale 1ns / 1ps

module fcet_run_cmp import fcet_pkg::*; (
  input  logic [CL_W-1:0] base,
  input  logic [CL_W-1:0] len,
  input  logic [CL_W-1:0] c,
  output run_cmp_t        res
);

  logic [CL_W:0] sum;
  logic [CL_W:0] c_ext;

  assign sum   = {1'b0, base} + {1'b0, len};
  assign c_ext = {1'b0, c};

  // Range test, end and base detection, neighbor clusters
  always_comb begin
    res.hit     = (len != '0) && (c >= base) && (c_ext < sum);
    res.at_last = (c_ext + (CL_W+1)'(1)) == sum;
    res.at_base = c == base;
    res.contig  = (len != CL_MASK) && (c_ext == sum);
    res.last    = CL_W'(sum - (CL_W+1)'(1));
    res.c_inc   = c + CL_W'(1);
    res.c_dec   = c - CL_W'(1);
  end

endmodule

FILE: design/fcet_seq.sv
// Command sequencer: builds the run table, scans it for queries and keeps
// the head stack. Drives the run RAM and the shared compare unit.
// Depends on fcet_pkg.
`timescale 1ns / 1ps

module fcet_seq import fcet_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              fat32_mode,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  logic [CL_W-1:0]   in_cluster,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [2:0]        res_status,
  output logic [CL_W-1:0]   res_cluster,
  output run_wr_t           wr,
  output logic [RIDX_W-1:0] raddr,
  input  run_rd_t           rd,
  output logic [CL_W-1:0]   cmp_c,
  input  run_cmp_t          cmp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_NEXT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [1:0]        cmd_q;
  logic [CL_W-1:0]   c_q;
  logic [RIDX_W-1:0] scan_idx;
  logic [RIDX_W-1:0] cur;
  logic              complete;
  logic              full;
  logic [CL_W-1:0]   base0;
  logic [HIDX_W-1:0] hc;
  logic [CL_W-1:0]   head_stack [HEAD_ENTRIES];
  logic [CL_W-1:0]   prev_last;
  logic              accept;
  logic              is_end;

  assign in_ready    = state == S_IDLE;
  assign accept      = in_valid && in_ready;
  assign res_valid   = state == S_DONE;
  assign cmp_c       = c_q;
  assign is_end      = (!fat32_mode && in_cluster == END16) ||
                       in_cluster == END32A || in_cluster == END32B;

  // Run RAM read address: current run on an entry, next scan slot otherwise
  always_comb begin
    if (state == S_IDLE) begin
      raddr = (in_cmd == CMD_ENTRY) ? cur : '0;
    end else begin
      raddr = scan_idx + RIDX_W'(1);
    end
  end

  // Run RAM writes: start, run lengthening, new run
  always_comb begin
    wr      = '0;
    wr.addr = cur;
    if (accept && in_cmd == CMD_START) begin
      wr.we   = 1'b1;
      wr.clr  = 1'b1;
      wr.addr = '0;
      wr.base = in_cluster;
      wr.len  = CL_W'(1);
    end else if (state == S_EVAL) begin
      if (cmp.contig) begin
        wr.we   = 1'b1;
        wr.base = rd.base;
        wr.len  = rd.len + CL_W'(1);
      end else if (cur != RUN_LAST) begin
        wr.we   = 1'b1;
        wr.addr = cur + RIDX_W'(1);
        wr.base = c_q;
        wr.len  = CL_W'(1);
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_START) begin
            state_next = S_DONE;
          end else if (in_cmd == CMD_ENTRY) begin
            state_next = (complete || full || is_end) ? S_DONE : S_EVAL;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_EVAL: state_next = S_DONE;
      S_SCAN: begin
        if (cmp.hit) begin
          if (cmd_q == CMD_NEXT && cmp.at_last && scan_idx != RUN_LAST) begin
            state_next = S_NEXT;
          end else begin
            state_next = S_DONE;
          end
        end else if (scan_idx == RUN_LAST || !rd.valid) begin
          state_next = S_DONE;
        end
      end
      S_NEXT: state_next = S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cur      <= '0;
      complete <= 1'b0;
      full     <= 1'b0;
      base0    <= '0;
      hc       <= '0;
      scan_idx <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          scan_idx <= '0;
          if (accept && in_cmd == CMD_START) begin
            cur      <= '0;
            complete <= 1'b0;
            full     <= 1'b0;
            base0    <= in_cluster;
          end else if (accept && in_cmd == CMD_ENTRY && !complete && !full && is_end) begin
            complete <= 1'b1;
          end
        end
        S_EVAL: begin
          if (!cmp.contig) begin
            if (cur == RUN_LAST) begin
              full <= 1'b1;
            end else begin
              cur <= cur + RIDX_W'(1);
            end
          end
        end
        S_SCAN: begin
          if (cmp.hit) begin
            if (cmd_q == CMD_NEXT && cmp.at_last && scan_idx == RUN_LAST &&
                !complete && hc != HC_MAX) begin
              hc <= hc + HIDX_W'(1);
            end else if (cmd_q == CMD_PREV && cmp.at_base && scan_idx == '0 &&
                         hc != '0) begin
              hc <= hc - HIDX_W'(1);
            end
          end else begin
            scan_idx <= scan_idx + RIDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Head stack push of the current table head
  always_ff @(posedge clk) begin
    if (state == S_SCAN && cmp.hit && cmd_q == CMD_NEXT && cmp.at_last &&
        scan_idx == RUN_LAST && !complete && hc != HC_MAX) begin
      head_stack[hc] <= base0;
    end
  end

  // Latch the command, track the previous run's end and form the result
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= in_cmd;
      c_q   <= in_cluster;
    end
    prev_last <= cmp.last;
    case (state)
      S_IDLE: begin
        res_status  <= ST_OK;
        res_cluster <= in_cluster;
        if (in_cmd == CMD_ENTRY) begin
          if (complete) begin
            res_status  <= ST_DONE;
            res_cluster <= '0;
          end else if (full) begin
            res_status  <= ST_FULL;
            res_cluster <= '0;
          end else if (is_end) begin
            res_status  <= ST_DONE;
            res_cluster <= '0;
          end
        end
      end
      S_EVAL: begin
        if (!cmp.contig && cur == RUN_LAST) begin
          res_status  <= ST_FULL;
          res_cluster <= '0;
        end else begin
          res_status  <= ST_OK;
          res_cluster <= c_q;
        end
      end
      S_SCAN: begin
        if (cmp.hit) begin
          if (cmd_q == CMD_NEXT) begin
            if (!cmp.at_last) begin
              res_status  <= ST_OK;
              res_cluster <= cmp.c_inc;
            end else if (complete) begin
              res_status  <= ST_EOF;
              res_cluster <= '0;
            end else begin
              res_status  <= ST_RELOAD;
              res_cluster <= c_q;
            end
          end else begin
            if (!cmp.at_base) begin
              res_status  <= ST_OK;
              res_cluster <= cmp.c_dec;
            end else if (scan_idx != '0) begin
              res_status  <= ST_OK;
              res_cluster <= prev_last;
            end else if (hc != '0) begin
              res_status  <= ST_RELOAD;
              res_cluster <= head_stack[hc - HIDX_W'(1)];
            end else begin
              res_status  <= ST_START;
              res_cluster <= c_q;
            end
          end
        end else begin
          res_status  <= ST_NOTFOUND;
          res_cluster <= '0;
        end
      end
      S_NEXT: begin
        if (rd.len == '0) begin
          res_status  <= ST_EOF;
          res_cluster <= '0;
        end else begin
          res_status  <= ST_OK;
          res_cluster <= rd.base;
        end
      end
      default: ;
    endcase
  end

endmodule
